@@ hdl/obt_pkg.sv @@
`timescale 1ns / 1ps

package obt_pkg;

  localparam int PRICE_W = 32;
  localparam int ID_W    = 64;
  localparam int SEQ_W   = 64;
  localparam int STAT_W  = 2;

  // Update kinds
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;

  // Order sides
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_ADDED     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_CANCELLED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNKNOWN   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  // One order table entry as held in the slot memory
  typedef struct packed {
    logic               used;
    logic               canc;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [ID_W-1:0]    ord_key;
  } slot_t;

endpackage

@@ hdl/order_book_top_of_book.sv @@
`timescale 1ns / 1ps

// Top-of-book tracker for one limit order book. Each input item adds an order
// (id, side, price) or cancels one by id; each produces exactly one result item
// with the best bid (highest buy price), the best ask (lowest sell price), the
// item's sequence number and a status (added, cancelled, unknown id, or add
// dropped because the table is full). An empty side reports 0. Orders sit in a
// single-port-write, registered-read slot memory of ORDER_SLOTS entries, and one
// compare unit walks that memory once per item: it matches the id, finds the
// lowest free slot and rebuilds the best bid and ask in the same pass. An item
// therefore occupies the block from accept through the scan, which reads every
// slot and processes each behind the registered read, and then the commit, as
// the slot memory has one read port. in_stall_o stays high for that time. After
// reset, a clearing pass over all ORDER_SLOTS entries empties the memory before
// the first item is taken. A result waiting on out_stall_i does not block the
// next item; it only holds that item's commit until the output register frees.
module order_book_top_of_book #(
  parameter int ORDER_SLOTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic        side_i,
  input  logic [31:0] price_i,
  input  logic [63:0] ord_key_i,
  input  logic [63:0] seq_num_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] best_bid_o,
  output logic [31:0] best_ask_o,
  output logic [63:0] last_seq_o,
  output logic [1:0]  status_o
);

  localparam int IDX_W = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int CNT_W = IDX_W + 1;

  // Slot memory: one write and one registered read per cycle
  obt_pkg::slot_t mem [ORDER_SLOTS];
  obt_pkg::slot_t rd_data_q;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  obt_pkg::slot_t   wr_data;

  obt_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q;       // sweep / scan position
  logic [CNT_W-1:0] used_cnt_q;  // number of occupied slots

  // Latched update
  logic                       cmd_q;
  logic                       side_q;
  logic [obt_pkg::PRICE_W-1:0] price_q;
  logic [obt_pkg::ID_W-1:0]    id_q;
  logic [obt_pkg::SEQ_W-1:0]   seq_q;
  logic                       full_q;

  // Scan accumulators
  logic                        free_found_q;
  logic [IDX_W-1:0]            free_idx_q;
  logic                        hit_q;
  logic                        have_bid_q;
  logic                        have_ask_q;
  logic [obt_pkg::PRICE_W-1:0] bid_q;
  logic [obt_pkg::PRICE_W-1:0] ask_q;

  // Output register
  logic                        out_valid_q;
  logic [obt_pkg::PRICE_W-1:0] best_bid_q;
  logic [obt_pkg::PRICE_W-1:0] best_ask_q;
  logic [obt_pkg::SEQ_W-1:0]   last_seq_q;
  logic [obt_pkg::STAT_W-1:0]  status_q;

  // Step signals of the shared compare unit
  logic             in_acc;
  logic             proc_en;
  logic [IDX_W-1:0] proc_idx;
  logic             add_live;
  logic             id_hit;
  logic             take_free;
  logic             unlink;
  logic             cancel_hit;
  logic             counted;
  logic             bid_upd;
  logic             ask_upd;
  logic             scan_last;
  logic             commit_go;

  // Commit results
  logic                        new_bid;
  logic                        new_ask;
  logic [obt_pkg::PRICE_W-1:0] fin_bid;
  logic [obt_pkg::PRICE_W-1:0] fin_ask;
  logic [obt_pkg::STAT_W-1:0]  fin_stat;

  assign in_stall_o  = (state_q != obt_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign best_bid_o  = best_bid_q;
  assign best_ask_o  = best_ask_q;
  assign last_seq_o  = last_seq_q;
  assign status_o    = status_q;

  // Read slot cnt while the slot read in the previous cycle is processed
  assign rd_addr   = cnt_q[IDX_W-1:0];
  assign proc_en   = (state_q == obt_pkg::ST_SCAN) && (cnt_q != '0);
  assign proc_idx  = IDX_W'(cnt_q - CNT_W'(1));
  assign scan_last = (cnt_q == CNT_W'(ORDER_SLOTS));
  assign add_live  = (cmd_q == obt_pkg::CMD_ADD) && !full_q;

  // One entry per cycle: id match, free-slot search, best price compare
  assign id_hit     = rd_data_q.used && (rd_data_q.ord_key == id_q);
  assign take_free  = proc_en && add_live && !rd_data_q.used && !free_found_q;
  assign unlink     = proc_en && add_live && id_hit && rd_data_q.canc;
  assign cancel_hit = proc_en && (cmd_q == obt_pkg::CMD_CANCEL) && !hit_q
                      && id_hit && rd_data_q.canc;
  assign counted    = proc_en && rd_data_q.used && !cancel_hit;
  assign bid_upd    = counted && (rd_data_q.side == obt_pkg::SIDE_BUY)
                      && (!have_bid_q || (rd_data_q.price > bid_q));
  assign ask_upd    = counted && (rd_data_q.side == obt_pkg::SIDE_SELL)
                      && (!have_ask_q || (rd_data_q.price < ask_q));

  // Fold the new order into the top of book at commit
  assign new_bid  = add_live && (side_q == obt_pkg::SIDE_BUY)
                    && (!have_bid_q || (price_q > bid_q));
  assign new_ask  = add_live && (side_q == obt_pkg::SIDE_SELL)
                    && (!have_ask_q || (price_q < ask_q));
  assign fin_bid  = new_bid ? price_q : bid_q;
  assign fin_ask  = new_ask ? price_q : ask_q;
  assign commit_go = !out_valid_q || !out_stall_i;

  always_comb begin
    if (cmd_q == obt_pkg::CMD_ADD) begin
      fin_stat = full_q ? obt_pkg::STAT_FULL : obt_pkg::STAT_ADDED;
    end else begin
      fin_stat = hit_q ? obt_pkg::STAT_CANCELLED : obt_pkg::STAT_UNKNOWN;
    end
  end

  // Sequencer and memory write control
  always_comb begin
    state_d = state_q;
    wr_en   = 1'b0;
    wr_addr = proc_idx;
    wr_data = rd_data_q;
    case (state_q)
      obt_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_q[IDX_W-1:0];
        wr_data = '0;
        if (cnt_q == CNT_W'(ORDER_SLOTS - 1)) begin
          state_d = obt_pkg::ST_IDLE;
        end
      end
      obt_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = obt_pkg::ST_SCAN;
        end
      end
      obt_pkg::ST_SCAN: begin
        if (unlink) begin
          wr_en        = 1'b1;
          wr_data.canc = 1'b0;
        end else if (cancel_hit) begin
          wr_en        = 1'b1;
          wr_data.used = 1'b0;
          wr_data.canc = 1'b0;
        end
        if (scan_last) begin
          state_d = obt_pkg::ST_COMMIT;
        end
      end
      obt_pkg::ST_COMMIT: begin
        wr_addr          = free_idx_q;
        wr_data.used     = 1'b1;
        wr_data.canc     = 1'b1;
        wr_data.side     = side_q;
        wr_data.price    = price_q;
        wr_data.ord_key  = id_q;
        if (commit_go) begin
          wr_en   = add_live;
          state_d = obt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = obt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= obt_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Sweep counter and occupancy count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      used_cnt_q <= '0;
    end else begin
      case (state_q)
        obt_pkg::ST_CLEAR: begin
          cnt_q <= (state_d == obt_pkg::ST_IDLE) ? '0 : cnt_q + CNT_W'(1);
        end
        obt_pkg::ST_IDLE: begin
          cnt_q <= '0;
        end
        obt_pkg::ST_SCAN: begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
        obt_pkg::ST_COMMIT: begin
          if (commit_go) begin
            cnt_q <= '0;
            if (add_live) begin
              used_cnt_q <= used_cnt_q + CNT_W'(1);
            end else if (hit_q) begin
              used_cnt_q <= used_cnt_q - CNT_W'(1);
            end
          end
        end
        default: begin
          cnt_q <= '0;
        end
      endcase
    end
  end

  // Latch the update and run the scan accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q       <= 1'b0;
      free_found_q <= 1'b0;
      hit_q        <= 1'b0;
      have_bid_q   <= 1'b0;
      have_ask_q   <= 1'b0;
    end else if (in_acc) begin
      full_q       <= (used_cnt_q == CNT_W'(ORDER_SLOTS));
      free_found_q <= 1'b0;
      hit_q        <= 1'b0;
      have_bid_q   <= 1'b0;
      have_ask_q   <= 1'b0;
    end else begin
      if (take_free) begin
        free_found_q <= 1'b1;
      end
      if (cancel_hit) begin
        hit_q <= 1'b1;
      end
      if (bid_upd) begin
        have_bid_q <= 1'b1;
      end
      if (ask_upd) begin
        have_ask_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= cmd_i;
      side_q  <= side_i;
      price_q <= price_i;
      id_q    <= ord_key_i;
      seq_q   <= seq_num_i;
      bid_q   <= '0;
      ask_q   <= '0;
    end else begin
      if (take_free) begin
        free_idx_q <= proc_idx;
      end
      if (bid_upd) begin
        bid_q <= rd_data_q.price;
      end
      if (ask_upd) begin
        ask_q <= rd_data_q.price;
      end
    end
  end

  // Output register: hold while stalled, load at commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == obt_pkg::ST_COMMIT) && commit_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == obt_pkg::ST_COMMIT) && commit_go) begin
      best_bid_q <= fin_bid;
      best_ask_q <= fin_ask;
      last_seq_q <= seq_q;
      status_q   <= fin_stat;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_cnt_q <= CNT_W'(ORDER_SLOTS))
    else $error("occupancy count beyond table size");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == obt_pkg::ST_SCAN) && (cnt_q == '0))
    else $error("accepted item did not start a scan");

  a_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == obt_pkg::ST_COMMIT) && add_live |-> free_found_q)
    else $error("add committed without a free slot");

  a_hit_cancel_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q && (state_q != obt_pkg::ST_IDLE) |-> (cmd_q == obt_pkg::CMD_CANCEL))
    else $error("cancel hit recorded on an add");

  a_commit_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == obt_pkg::ST_COMMIT) && commit_go |=> out_valid_q)
    else $error("commit did not load the output register");
`endif

endmodule
